>>> rtl/priority_ready_queue_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority ready queue scheduler
// Clocked on clock, disabled while reset is high; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PRQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);
`define PRQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define PRQ_ASSERT(lbl, prop, msg)
`define PRQ_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Types and codes shared by the priority ready queue scheduler modules.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int DEFAULT_MAX_TASKS = 16;
   localparam int ID_W              = 4;
   localparam int ID_COUNT          = 2 ** ID_W;
   localparam int LVL_W             = 2;
   localparam int NUM_LEVELS        = 3;

   localparam logic [1:0] ACT_CREATE  = 2'd0;
   localparam logic [1:0] ACT_TIMEOUT = 2'd1;
   localparam logic [1:0] ACT_RESET   = 2'd2;

   localparam logic [LVL_W-1:0] LVL_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]       action;
      logic [ID_W-1:0]  task_id;
      logic [LVL_W-1:0] level;
   } req_type;

   typedef struct packed {
      logic            ok;
      logic [ID_W-1:0] running_task;
      logic            switched;
   } rsp_type;

endpackage

>>> rtl/prq_store.sv
// ----------------------------------------------------------------------------
// prq_store
// Ready queue memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prq_store #(
   parameter int DEPTH  = 48,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Scheduler sequencer: queue heads and counts, task flags, running task,
// and the read-modify-write of the ready queue memory.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_scheduler_assert.svh"

module prq_ctrl #(
   parameter int MAX_TASKS = prq_pkg::DEFAULT_MAX_TASKS,
   parameter int ADDR_W    = $clog2(prq_pkg::NUM_LEVELS * MAX_TASKS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  prq_pkg::req_type      req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output prq_pkg::rsp_type      rsp_item,
   output logic                  mem_we,
   output logic [ADDR_W-1:0]     mem_waddr,
   output logic [prq_pkg::ID_W-1:0] mem_wdata,
   output logic [ADDR_W-1:0]     mem_raddr,
   input  logic [prq_pkg::ID_W-1:0] mem_rdata
);

   import prq_pkg::*;

   localparam int NUM_IDS = (MAX_TASKS < ID_COUNT) ? MAX_TASKS : ID_COUNT;
   localparam int IDX_W   = $clog2(NUM_IDS);
   localparam int HEAD_W  = $clog2(MAX_TASKS);
   localparam int COUNT_W = $clog2(MAX_TASKS + 1);
   localparam int SUM_W   = COUNT_W + 1;

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [HEAD_W-1:0]  head_s_ff, head_s_in;
   logic [COUNT_W-1:0] count_s_ff, count_s_in;
   logic [HEAD_W-1:0]  head_ff [NUM_LEVELS];
   logic [HEAD_W-1:0]  head_in [NUM_LEVELS];
   logic [COUNT_W-1:0] count_ff [NUM_LEVELS];
   logic [COUNT_W-1:0] count_in [NUM_LEVELS];
   logic [NUM_IDS-1:0] present_ff, present_in;
   logic [ID_W-1:0]    cur_ff, cur_in;
   logic [LVL_W-1:0]   cur_lvl_ff, cur_lvl_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [LVL_W-1:0]   sel_lvl;
   logic [HEAD_W-1:0]  head_sel;
   logic [COUNT_W-1:0] count_sel;
   logic [IDX_W-1:0]   id_idx;
   logic               id_ok;
   logic               create_ok;

   function automatic logic [HEAD_W-1:0] wrap_idx(input logic [HEAD_W-1:0] h,
                                                  input logic [COUNT_W-1:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(h) + SUM_W'(n);
      if (s >= SUM_W'(MAX_TASKS)) begin
         s = s - SUM_W'(MAX_TASKS);
      end
      return s[HEAD_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lv);
      logic [ADDR_W-1:0] b;
      case (lv)
         2'd1:    b = ADDR_W'(MAX_TASKS);
         2'd2:    b = ADDR_W'(2 * MAX_TASKS);
         default: b = '0;
      endcase
      return b;
   endfunction

   // Level looked at by the incoming item; timeout works on the running level.
   always_comb begin
      sel_lvl   = (req_item.action == ACT_TIMEOUT) ? cur_lvl_ff : req_item.level;
      head_sel  = head_ff[0];
      count_sel = count_ff[0];
      for (int l = 1; l < NUM_LEVELS; l++) begin
         if (sel_lvl == LVL_W'(l)) begin
            head_sel  = head_ff[l];
            count_sel = count_ff[l];
         end
      end
      // entry behind the front: next task after a rotate
      mem_raddr = level_base(sel_lvl) + ADDR_W'(wrap_idx(head_sel, COUNT_W'(1)));
   end

   assign id_idx    = req_ff.task_id[IDX_W-1:0];
   assign id_ok     = {1'b0, req_ff.task_id} < (ID_W + 1)'(NUM_IDS);
   assign create_ok = id_ok && (req_ff.level != LVL_INVALID) && !present_ff[id_idx]
                      && (count_s_ff < COUNT_W'(MAX_TASKS));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_s_in    = head_s_ff;
      count_s_in   = count_s_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      cur_in       = cur_ff;
      cur_lvl_in   = cur_lvl_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;

      unique case (state_ff)
         ST_INIT: begin
            // init task 0 at front of level 0
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_EXEC;
               req_in     = req_item;
               head_s_in  = head_sel;
               count_s_in = count_sel;
            end
         end
         ST_EXEC: begin
            state_in        = ST_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_in.ok       = 1'b0;
            rsp_in.switched = 1'b0;
            unique case (req_ff.action)
               ACT_CREATE: begin
                  if (create_ok) begin
                     present_in[id_idx] = 1'b1;
                     mem_we    = 1'b1;
                     mem_waddr = level_base(req_ff.level)
                                 + ADDR_W'(wrap_idx(head_s_ff, count_s_ff));
                     mem_wdata = req_ff.task_id;
                     for (int l = 0; l < NUM_LEVELS; l++) begin
                        if (req_ff.level == LVL_W'(l)) begin
                           count_in[l] = count_s_ff + COUNT_W'(1);
                        end
                     end
                     // a higher level was empty until now: new item preempts
                     if (req_ff.level > cur_lvl_ff) begin
                        cur_in          = req_ff.task_id;
                        cur_lvl_in      = req_ff.level;
                        rsp_in.switched = 1'b1;
                     end
                     rsp_in.ok = 1'b1;
                  end
               end
               ACT_TIMEOUT: begin
                  // running task is the front of the top level: rotate it
                  for (int l = 0; l < NUM_LEVELS; l++) begin
                     if (cur_lvl_ff == LVL_W'(l)) begin
                        head_in[l] = wrap_idx(head_s_ff, COUNT_W'(1));
                     end
                  end
                  mem_we    = 1'b1;
                  mem_waddr = level_base(cur_lvl_ff)
                              + ADDR_W'(wrap_idx(head_s_ff, count_s_ff));
                  mem_wdata = cur_ff;
                  if (count_s_ff > COUNT_W'(1)) begin
                     cur_in          = mem_rdata;
                     rsp_in.switched = (mem_rdata != cur_ff);
                  end
                  rsp_in.ok = 1'b1;
               end
               ACT_RESET: begin
                  for (int l = 0; l < NUM_LEVELS; l++) begin
                     head_in[l]  = '0;
                     count_in[l] = '0;
                  end
                  count_in[0]     = COUNT_W'(1);
                  present_in      = NUM_IDS'(1);
                  cur_in          = '0;
                  cur_lvl_in      = '0;
                  mem_we          = 1'b1;
                  rsp_in.switched = (cur_ff != '0);
                  rsp_in.ok       = 1'b1;
               end
               default: begin
               end
            endcase
            rsp_in.running_task = cur_in;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= (l == 0) ? COUNT_W'(1) : '0;
         end
         present_ff   <= NUM_IDS'(1);
         cur_ff       <= '0;
         cur_lvl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         cur_ff       <= cur_in;
         cur_lvl_ff   <= cur_lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      head_s_ff  <= head_s_in;
      count_s_ff <= count_s_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `PRQ_ASSERT(a_lvl0_nonempty, count_ff[0] != '0, "level 0 queue lost the init task")
   `PRQ_ASSERT(a_cur_present, present_ff[cur_ff[IDX_W-1:0]], "running task not present")
   `PRQ_ASSERT_IMP(a_rsp_after_exec, rsp_valid_ff, $past(state_ff == ST_EXEC), "stray rsp")
   `PRQ_ASSERT_IMP(a_reject_no_switch, rsp_valid_ff && !rsp_ff.ok, !rsp_ff.switched, "reject switched")

endmodule

>>> rtl/priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Three-level preemptive fixed-priority scheduler with FIFO ready queues.
// ----------------------------------------------------------------------------
//   channel  ports                      direction  handshake
//   request  start, busy, req_item      in         start & !busy
//   response rsp_valid, rsp_item        out        rsp_valid, one cycle
//
// For each item, the accept cycle reads the level's head and count and
// launches the queue memory read of the entry behind the front; the next
// cycle updates state and writes the memory. The registered response
// strobe follows in the cycle after that, while a new item may already be
// accepted. After reset, busy stays high while the init task is written.
// The receiver cannot stall; every response is shown exactly once.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler #(
   parameter int MAX_TASKS = prq_pkg::DEFAULT_MAX_TASKS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  prq_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output prq_pkg::rsp_type rsp_item
);

   import prq_pkg::*;

   localparam int DEPTH  = NUM_LEVELS * MAX_TASKS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ID_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [ID_W-1:0]   mem_rdata;

   prq_ctrl #(
      .MAX_TASKS (MAX_TASKS),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   prq_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (ID_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

>>> tb/tb_priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler
// Self-checking bench for the three-level preemptive scheduler. A driver
// feeds create, timeout, reset and spare commands from a queue; each accepted item
// is run through a local model of the ready queues to predict the running id,
// the ok flag and the switch flag, and a monitor checks every response strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import prq_pkg::*;

   localparam int          N_TASKS      = DEFAULT_MAX_TASKS;
   localparam int          CYCLE_LIMIT  = 100000;
   localparam int          SETTLE_TICKS = 16;
   localparam int          RANDOM_ITEMS = 1700;
   localparam logic [1:0]  ACT_SPARE    = 2'd3;

   typedef struct {
      req_type item;
      bit      drain_first;
   } cmd_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   priority_ready_queue_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // scheduler model state
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]  ready_fifo [NUM_LEVELS][N_TASKS];
   int unsigned      fifo_head  [NUM_LEVELS];
   int unsigned      fifo_len   [NUM_LEVELS];
   bit               id_live    [N_TASKS];
   logic [LVL_W-1:0] id_level   [N_TASKS];
   logic [ID_W-1:0]  run_id;
   bit               run_active;

   cmd_type  cmd_queue [$];
   rsp_type  expected_rsp [$];
   cmd_type  next_cmd;
   bit       drain_request;

   int n_random, n_accepted, n_seen, n_errors, cycle_count;
   int n_create_ok, n_create_rej, n_timeout, n_restart, n_switch, n_spare;

   function automatic void sched_clear();
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         fifo_head[lv] = 0;
         fifo_len[lv]  = 0;
         for (int p = 0; p < N_TASKS; p++) ready_fifo[lv][p] = '0;
      end
      for (int t = 0; t < N_TASKS; t++) begin
         id_live[t]  = 1'b0;
         id_level[t] = '0;
      end
      id_live[0]  = 1'b1;
      fifo_len[0] = 1;
      run_id      = '0;
      run_active  = 1'b1;
   endfunction

   function automatic void fifo_append(int unsigned lv, logic [ID_W-1:0] id);
      if (lv >= NUM_LEVELS || fifo_len[lv] >= N_TASKS) return;
      ready_fifo[lv][(fifo_head[lv] + fifo_len[lv]) % N_TASKS] = id;
      fifo_len[lv]++;
   endfunction

   function automatic void fifo_unlink(int unsigned lv, logic [ID_W-1:0] id);
      int unsigned n, pos;
      if (lv >= NUM_LEVELS) return;
      n   = fifo_len[lv];
      pos = n;
      for (int unsigned i = 0; i < n && pos == n; i++)
         if (ready_fifo[lv][(fifo_head[lv] + i) % N_TASKS] == id) pos = i;
      if (pos >= n) return;
      if (pos == 0) begin
         fifo_head[lv] = (fifo_head[lv] + 1) % N_TASKS;
      end else begin
         for (int unsigned k = pos; k + 1 < n; k++)
            ready_fifo[lv][(fifo_head[lv] + k) % N_TASKS] =
               ready_fifo[lv][(fifo_head[lv] + k + 1) % N_TASKS];
      end
      fifo_len[lv] = n - 1;
   endfunction

   // pick the front of the highest non-empty level; preempt if warranted
   function automatic bit dispatch();
      int              top;
      logic [ID_W-1:0] best, prev;
      prev = run_id;
      top  = -1;
      for (int lv = NUM_LEVELS - 1; lv >= 0; lv--)
         if (top < 0 && fifo_len[lv] != 0) top = lv;
      if (top < 0) return 1'b0;
      best = ready_fifo[top][fifo_head[top] % N_TASKS];
      if (!run_active || int'(id_level[run_id]) < top) begin
         run_id     = best;
         run_active = 1'b1;
         return best != prev;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type sched_step(req_type r);
      rsp_type          res;
      logic [ID_W-1:0]  prev;
      logic [LVL_W-1:0] lv_cur;
      res = '0;
      case (r.action)
         ACT_CREATE: begin
            if (r.level < NUM_LEVELS && !id_live[r.task_id]) begin
               id_live[r.task_id]  = 1'b1;
               id_level[r.task_id] = r.level;
               fifo_append(int'(r.level), r.task_id);
               res.switched = dispatch();
               res.ok       = 1'b1;
               n_create_ok++;
            end else begin
               n_create_rej++;
            end
         end
         ACT_TIMEOUT: begin
            lv_cur = id_level[run_id];
            fifo_unlink(int'(lv_cur), run_id);
            fifo_append(int'(lv_cur), run_id);
            run_active   = 1'b0;
            res.switched = dispatch();
            res.ok       = 1'b1;
            n_timeout++;
         end
         ACT_RESET: begin
            prev = run_id;
            sched_clear();
            run_active = 1'b0;
            void'(dispatch());
            res.switched = (run_id != prev);
            res.ok       = 1'b1;
            n_restart++;
         end
         default: n_spare++;
      endcase
      res.running_task = run_id;
      if (res.switched) n_switch++;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic void push_cmd(logic [1:0] act, logic [ID_W-1:0] id,
                                    logic [LVL_W-1:0] lv);
      cmd_type c;
      c.item.action  = act;
      c.item.task_id = id;
      c.item.level   = lv;
      c.drain_first  = drain_request;
      drain_request  = 1'b0;
      cmd_queue.insert(cmd_queue.size(), c);
   endfunction

   function automatic void push_random(logic [1:0] act, logic [ID_W-1:0] id,
                                       logic [LVL_W-1:0] lv);
      push_cmd(act, id, lv);
      if (act != ACT_SPARE) begin
         n_random++;
         // hold off now and then until everything outstanding has come back
         if (n_random % 400 == 0) drain_request = 1'b1;
      end
   endfunction

   function automatic void build_stimulus();
      logic [ID_W-1:0]  ids [15];
      logic [ID_W-1:0]  tmp;
      logic [LVL_W-1:0] fixed_lvl;
      bit               one_level;
      int               j, n_create, n_rot;

      // directed: corner cases from the init state onward
      push_cmd(ACT_TIMEOUT, 4'd0,  2'd0);   // init alone, re-dispatched
      push_cmd(ACT_CREATE,  4'd0,  2'd0);   // duplicate id
      push_cmd(ACT_CREATE,  4'd5,  LVL_INVALID);
      push_cmd(ACT_SPARE,   4'd15, 2'd3);
      push_cmd(ACT_CREATE,  4'd1,  2'd0);   // same level, no preemption
      push_cmd(ACT_TIMEOUT, 4'd0,  2'd0);
      push_cmd(ACT_CREATE,  4'd10, 2'd1);   // preempts
      push_cmd(ACT_CREATE,  4'd15, 2'd2);   // preempts
      push_cmd(ACT_CREATE,  4'd6,  2'd2);
      push_cmd(ACT_TIMEOUT, 4'd0,  2'd0);
      push_cmd(ACT_TIMEOUT, 4'd0,  2'd0);
      push_cmd(ACT_CREATE,  4'd15, 2'd1);   // duplicate at another level
      push_cmd(ACT_RESET,   4'd7,  2'd2);   // back to init with a switch
      push_cmd(ACT_RESET,   4'd0,  2'd0);   // init already running
      push_cmd(ACT_CREATE,  4'd9,  2'd2);
      push_cmd(ACT_CREATE,  4'd2,  2'd1);
      push_cmd(ACT_TIMEOUT, 4'd0,  2'd0);
      push_cmd(ACT_CREATE,  4'd12, 2'd0);
      push_cmd(ACT_TIMEOUT, 4'd0,  2'd0);
      push_cmd(ACT_SPARE,   4'd0,  2'd0);
      drain_request = 1'b1;

      while (n_random < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 15) begin
            push_random(2'($urandom_range(3)), ID_W'($urandom_range(15)),
                        LVL_W'($urandom_range(3)));
         end else begin
            for (int i = 0; i < 15; i++) ids[i] = ID_W'(i + 1);
            for (int i = 14; i > 0; i--) begin
               j      = $urandom_range(i);
               tmp    = ids[i];
               ids[i] = ids[j];
               ids[j] = tmp;
            end
            one_level = ($urandom_range(4) == 0);
            fixed_lvl = LVL_W'($urandom_range(2));
            n_create  = $urandom_range(15, 1);
            push_random(ACT_RESET, ID_W'($urandom_range(15)), LVL_W'($urandom_range(3)));
            for (int i = 0; i < n_create; i++) begin
               push_random(ACT_CREATE, ids[i],
                           one_level ? fixed_lvl : LVL_W'($urandom_range(2)));
               n_rot = 0;
               while (n_rot < 3 && $urandom_range(99) < 35) begin
                  push_random(ACT_TIMEOUT, ID_W'($urandom_range(15)),
                              LVL_W'($urandom_range(3)));
                  n_rot++;
               end
               if ($urandom_range(99) < 5)
                  push_random(ACT_CREATE, ids[$urandom_range(i)],
                              LVL_W'($urandom_range(3)));
            end
            n_rot = $urandom_range(6);
            for (int i = 0; i < n_rot; i++)
               push_random(ACT_TIMEOUT, ID_W'($urandom_range(15)),
                           LVL_W'($urandom_range(3)));
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit go;
      bit in_burst;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.insert(expected_rsp.size(), sched_step(req_item));
            n_accepted++;
         end
         if (!start || !busy) begin
            go       = 1'b0;
            in_burst = (n_accepted >= 700 && n_accepted < 1000);
            if (cmd_queue.size() != 0) begin
               next_cmd = cmd_queue[0];
               if (next_cmd.drain_first && expected_rsp.size() != 0) go = 1'b0;
               else if (!in_burst && $urandom_range(99) < 21) go = 1'b0;
               else go = 1'b1;
            end
            if (go) begin
               req_item <= next_cmd.item;
               cmd_queue.delete(0);
            end
            start <= go;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor
   // ---------------------------------------------------------------------
   task automatic flag_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         n_seen++;
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("response with no item outstanding: ok=%0b run=%0d sw=%0b",
                                 rsp_item.ok, rsp_item.running_task, rsp_item.switched));
         end else begin
            want = expected_rsp[0];
            expected_rsp.delete(0);
            if (rsp_item.ok !== want.ok || rsp_item.running_task !== want.running_task ||
                rsp_item.switched !== want.switched)
               flag_error($sformatf(
                  "response %0d: expected ok=%0b run=%0d sw=%0b, got ok=%0b run=%0d sw=%0b",
                  n_seen, want.ok, want.running_task, want.switched,
                  rsp_item.ok, rsp_item.running_task, rsp_item.switched));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsp.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequencing and final verdict
   // ---------------------------------------------------------------------
   initial begin
      sched_clear();
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (cmd_queue.size() != 0 || start || expected_rsp.size() != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (expected_rsp.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_rsp.size()));
      $display("covered %0d items: %0d creates taken, %0d rejected, %0d timeouts, %0d resets",
               n_accepted, n_create_ok, n_create_rej, n_timeout, n_restart);
      $display("%0d task switches, %0d unused codes, %0d responses, %0d mismatches",
               n_switch, n_spare, n_seen, n_errors);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_store.sv
rtl/prq_ctrl.sv
rtl/priority_ready_queue_scheduler.sv
tb/tb_priority_ready_queue_scheduler.sv
